@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define CSVLFS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define CSVLFS_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSVLFS_ASSERT_RST(lbl, prop, msg)
`define CSVLFS_ASSERT_ALL(lbl, prop, msg)
`endif

`endif

@@ design/csvlfs_pkg.sv @@
// ----------------------------------------------------------------------------
// csvlfs_pkg
// shared types, constants and helpers of the csv line field splitter
// ----------------------------------------------------------------------------
`default_nettype none

package csvlfs_pkg;

  localparam int SPACE_DEPTH_DEF = 16;
  localparam int CMD_DEPTH_DEF   = 4;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // classified request handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_content;
    logic       is_fend;
    logic       eol;
  } cmd_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

endpackage

`default_nettype wire

@@ design/csvlfs_if.sv @@
// ----------------------------------------------------------------------------
// csvlfs channel interfaces
// valid/ready channels for input bytes and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface csvlfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_line;

  modport source (output valid, output in_byte, output end_of_line, input ready);
  modport sink   (input valid, input in_byte, input end_of_line, output ready);
endinterface

interface csvlfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       field_done;
  logic       line_done;
  logic       ws_overflow;
  logic       last_of_run;

  modport source (output valid, output out_byte, output has_byte, output field_done,
                  output line_done, output ws_overflow, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input field_done,
                  input line_done, input ws_overflow, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ design/csvlfs_front.sv @@
// ----------------------------------------------------------------------------
// csvlfs_front
// accepts line bytes, tracks quoting and classifies each byte into a request
// ----------------------------------------------------------------------------
`default_nettype none

module csvlfs_front (
  input  wire                 clk,
  input  wire                 rst_n,
  csvlfs_in_if.sink           in_ch,
  input  wire                 q_full,
  output logic                push,
  output csvlfs_pkg::cmd_t    cmd
);

  logic qm_r, qm_nxt;
  logic qp_r, qp_nxt;
  logic acc;
  logic handled;
  logic qm_eff;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    qm_nxt         = qm_r;
    qp_nxt         = qp_r;
    handled        = 1'b0;
    qm_eff         = qm_r;
    cmd.data       = in_ch.in_byte;
    cmd.is_content = 1'b0;
    cmd.is_fend    = 1'b0;
    cmd.eol        = in_ch.end_of_line;
    if (qp_r) begin
      qp_nxt = 1'b0;
      if (in_ch.in_byte == csvlfs_pkg::CH_QUOTE) begin
        cmd.is_content = 1'b1;
        handled        = 1'b1;
      end else begin
        qm_eff = 1'b0;
      end
    end
    qm_nxt = qm_eff;
    if (!handled) begin
      if (in_ch.in_byte == csvlfs_pkg::CH_QUOTE) begin
        if (qm_eff) begin
          qp_nxt = 1'b1;
        end else begin
          qm_nxt = 1'b1;
        end
      end else if (in_ch.in_byte == csvlfs_pkg::CH_COMMA && !qm_eff) begin
        cmd.is_fend = 1'b1;
      end else begin
        cmd.is_content = 1'b1;
      end
    end
    if (in_ch.end_of_line) begin
      qm_nxt = 1'b0;
      qp_nxt = 1'b0;
    end
  end

  // toggling quotes without line end carry no work
  assign push = acc && (cmd.is_content || cmd.is_fend || cmd.eol);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r <= 1'b0;
      qp_r <= 1'b0;
    end else if (acc) begin
      qm_r <= qm_nxt;
      qp_r <= qp_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/csvlfs_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// csvlfs_cmd_fifo
// short request queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module csvlfs_cmd_fifo #(
  parameter int DEPTH = csvlfs_pkg::CMD_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  csvlfs_pkg::cmd_t    wr_cmd,
  input  wire                 pop,
  output csvlfs_pkg::cmd_t    head,
  output logic                empty,
  output logic                full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csvlfs_pkg::cmd_t slots_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign head    = slots_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wp_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

@@ design/csvlfs_back.sv @@
// ----------------------------------------------------------------------------
// csvlfs_back
// executes requests: whitespace trimming buffer, field ends, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module csvlfs_back #(
  parameter int SPACE_DEPTH = csvlfs_pkg::SPACE_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  csvlfs_pkg::cmd_t    head,
  input  wire                 empty,
  output logic                pop,
  csvlfs_out_if.source        out_ch
);

  localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int CW = $clog2(SPACE_DEPTH + 1);

  localparam logic [1:0] PH_MAIN  = 2'd0;
  localparam logic [1:0] PH_LOAD  = 2'd1;
  localparam logic [1:0] PH_FLUSH = 2'd2;
  localparam logic [1:0] PH_EOL   = 2'd3;

  logic [7:0]    space_mem [SPACE_DEPTH];
  logic [7:0]    rd_data_r;
  logic [CW-1:0] rd_addr;
  logic          we;

  logic [1:0]    ph_r, ph_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          seen_r, seen_nxt;
  logic          ovf_r, ovf_nxt;

  logic          out_valid_r;
  logic [7:0]    byte_r;
  logic          has_r, fd_r, ld_r, ov_r, last_r;

  logic          slot_free, emit;
  logic [7:0]    e_byte;
  logic          e_has, e_fd, e_ld, e_ov, e_last;
  logic          ws, buf_full;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign ws        = csvlfs_pkg::is_ws(head.data);
  assign buf_full  = (cnt_r == CW'(SPACE_DEPTH));

  always_comb begin
    pop      = 1'b0;
    emit     = 1'b0;
    e_byte   = 8'd0;
    e_has    = 1'b0;
    e_fd     = 1'b0;
    e_ld     = 1'b0;
    e_ov     = 1'b0;
    e_last   = 1'b0;
    we       = 1'b0;
    rd_addr  = idx_r;
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    seen_nxt = seen_r;
    ovf_nxt  = ovf_r;
    case (ph_r)
      PH_MAIN: begin
        if (!empty) begin
          if (head.is_content && !ws) begin
            if (cnt_r != '0) begin
              ph_nxt  = PH_LOAD;
              idx_nxt = '0;
            end else if (slot_free) begin
              emit     = 1'b1;
              e_byte   = head.data;
              e_has    = 1'b1;
              e_last   = !head.eol;
              seen_nxt = 1'b1;
              if (head.eol) begin
                ph_nxt = PH_EOL;
              end else begin
                pop = 1'b1;
              end
            end
          end else if (head.is_content) begin
            if (!head.eol) begin
              pop = 1'b1;
              if (seen_r) begin
                if (!buf_full) begin
                  we      = 1'b1;
                  cnt_nxt = cnt_r + CW'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end else if (slot_free) begin
              emit     = 1'b1;
              e_fd     = 1'b1;
              e_ld     = 1'b1;
              e_ov     = ovf_r || (seen_r && buf_full);
              e_last   = 1'b1;
              seen_nxt = 1'b0;
              cnt_nxt  = '0;
              ovf_nxt  = 1'b0;
              pop      = 1'b1;
            end
          end else if (slot_free) begin
            // comma field end, or bare line end
            emit     = 1'b1;
            e_fd     = 1'b1;
            e_ov     = ovf_r;
            seen_nxt = 1'b0;
            cnt_nxt  = '0;
            ovf_nxt  = 1'b0;
            if (head.is_fend) begin
              e_last = !head.eol;
              if (head.eol) begin
                ph_nxt = PH_EOL;
              end else begin
                pop = 1'b1;
              end
            end else begin
              e_ld   = 1'b1;
              e_last = 1'b1;
              pop    = 1'b1;
            end
          end
        end
      end
      PH_LOAD: begin
        ph_nxt = PH_FLUSH;
      end
      PH_FLUSH: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_byte = rd_data_r;
          e_has  = 1'b1;
          if (idx_r + CW'(1) == cnt_r) begin
            cnt_nxt = '0;
            idx_nxt = '0;
            ph_nxt  = PH_MAIN;
          end else begin
            idx_nxt = idx_r + CW'(1);
            rd_addr = idx_r + CW'(1);
          end
        end
      end
      PH_EOL: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_fd     = 1'b1;
          e_ld     = 1'b1;
          e_ov     = ovf_r;
          e_last   = 1'b1;
          seen_nxt = 1'b0;
          cnt_nxt  = '0;
          ovf_nxt  = 1'b0;
          pop      = 1'b1;
          ph_nxt   = PH_MAIN;
        end
      end
      default: begin
        ph_nxt = PH_MAIN;
      end
    endcase
  end

  // trailing whitespace buffer
  always_ff @(posedge clk) begin
    if (we) begin
      space_mem[cnt_r[AW-1:0]] <= head.data;
    end
    rd_data_r <= space_mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_MAIN;
      cnt_r       <= '0;
      idx_r       <= '0;
      seen_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
      seen_r <= seen_nxt;
      ovf_r  <= ovf_nxt;
      if (slot_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      byte_r <= e_byte;
      has_r  <= e_has;
      fd_r   <= e_fd;
      ld_r   <= e_ld;
      ov_r   <= e_ov;
      last_r <= e_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = byte_r;
  assign out_ch.has_byte    = has_r;
  assign out_ch.field_done  = fd_r;
  assign out_ch.line_done   = ld_r;
  assign out_ch.ws_overflow = ov_r;
  assign out_ch.last_of_run = last_r;

  `CSVLFS_ASSERT_RST(a_cnt_bound, (cnt_r <= CW'(SPACE_DEPTH)), "space count beyond depth")
  `CSVLFS_ASSERT_RST(a_flush_idx, (ph_r == PH_FLUSH) |-> (idx_r < cnt_r), "flush index out of range")
  `CSVLFS_ASSERT_RST(a_pop_head, pop |-> !empty, "request popped from empty queue")
  `CSVLFS_ASSERT_RST(a_out_kind, out_valid_r |-> !(has_r && fd_r), "result carries byte and field end")
  `CSVLFS_ASSERT_ALL(a_rst_out, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule

`default_nettype wire

@@ design/csv_line_field_splitter.sv @@
// path: a byte's first result goes through the request queue and the result
//   register; buffered whitespace released ahead of it is sent out first
// throughput: one byte per cycle while each byte gives at most one result and
//   the result channel does not stall; a byte giving several results holds
//   the queue until all are sent, and released spaces first pass a buffer load
// reset: synchronous active-low rst_n clears quoting, queue and field state
// ----------------------------------------------------------------------------
// csv_line_field_splitter
// splits csv line bytes into trimmed fields with quote handling
// ----------------------------------------------------------------------------
`default_nettype none

module csv_line_field_splitter #(
  parameter int SPACE_DEPTH = csvlfs_pkg::SPACE_DEPTH_DEF,
  parameter int CMD_DEPTH   = csvlfs_pkg::CMD_DEPTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  csvlfs_in_if.sink    in_ch,
  csvlfs_out_if.source out_ch
);

  csvlfs_pkg::cmd_t wr_cmd;
  csvlfs_pkg::cmd_t head;
  logic push, pop, empty, full;

  csvlfs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .push   (push),
    .cmd    (wr_cmd)
  );

  csvlfs_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  csvlfs_back #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
